// ===== src/cmdsplit_pkg.sv =====
// Shared constants, codes and handshake structs for the command line splitter.
`timescale 1ns / 1ps
`default_nettype none

package cmdsplit_pkg;

	localparam int MAX_RUN = 62;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);
	localparam int CHAR_W  = 16;
	localparam int CNT_W   = 15;
	localparam int KIND_W  = 2;

	localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;

	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TERM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

	typedef enum logic [1:0] {
		SEL_SLASH,
		SEL_CHAR,
		SEL_TERM,
		SEL_SUM
	} emit_sel_t;

	typedef struct packed {
		logic [RUN_W-1:0] nsl;
		logic             char_en;
		logic             term_en;
		logic             sum_en;
	} plan_t;

	typedef struct packed {
		logic      accept;
		logic      load;
		emit_sel_t sel;
		logic      last;
	} cmd_t;

	typedef struct packed {
		logic  out_free;
		logic  slash_one;
		plan_t plan;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/cmdsplit_ctrl.sv =====
// Result sequencer: walks the held backslashes, character, terminator and summary of an item.
`timescale 1ns / 1ps
`default_nettype none

module cmdsplit_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_tvalid,
	output logic                 in_tready,
	input  cmdsplit_pkg::stat_t  stat,
	output cmdsplit_pkg::cmd_t   cmd
);
	import cmdsplit_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLASH,
		ST_CHAR,
		ST_TERM,
		ST_SUM
	} ctrl_state_t;

	ctrl_state_t state_q, state_d, after_slash, after_char, after_term, plan_first;
	logic        char_q, term_q, sum_q;
	logic        final_now, emit, accept;

	always_comb begin
		after_term  = sum_q ? ST_SUM : ST_IDLE;
		after_char  = term_q ? ST_TERM : after_term;
		after_slash = char_q ? ST_CHAR : after_char;

		if (stat.plan.nsl != '0) begin
			plan_first = ST_SLASH;
		end else if (stat.plan.char_en) begin
			plan_first = ST_CHAR;
		end else if (stat.plan.term_en) begin
			plan_first = ST_TERM;
		end else if (stat.plan.sum_en) begin
			plan_first = ST_SUM;
		end else begin
			plan_first = ST_IDLE;
		end

		case (state_q)
			ST_SLASH: begin
				final_now = stat.slash_one && !char_q && !term_q && !sum_q;
				cmd.sel   = SEL_SLASH;
			end
			ST_CHAR: begin
				final_now = !term_q && !sum_q;
				cmd.sel   = SEL_CHAR;
			end
			ST_TERM: begin
				final_now = !sum_q;
				cmd.sel   = SEL_TERM;
			end
			ST_SUM: begin
				final_now = 1'b1;
				cmd.sel   = SEL_SUM;
			end
			default: begin
				final_now = 1'b0;
				cmd.sel   = SEL_SLASH;
			end
		endcase

		emit      = (state_q != ST_IDLE) && stat.out_free;
		in_tready = (state_q == ST_IDLE) || (emit && final_now);
		accept    = in_tvalid && in_tready;

		cmd.accept = accept;
		cmd.load   = emit;
		cmd.last   = final_now;

		state_d = state_q;
		if (accept) begin
			state_d = plan_first;
		end else if (emit) begin
			case (state_q)
				ST_SLASH: state_d = stat.slash_one ? after_slash : ST_SLASH;
				ST_CHAR:  state_d = after_char;
				ST_TERM:  state_d = after_term;
				default:  state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			char_q  <= 1'b0;
			term_q  <= 1'b0;
			sum_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				char_q <= stat.plan.char_en;
				term_q <= stat.plan.term_en;
				sum_q  <= stat.plan.sum_en;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/cmdsplit_dp.sv =====
// Parse state, backslash run counter, line counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module cmdsplit_dp (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire  [cmdsplit_pkg::CHAR_W-1:0]          in_char,
	input  cmdsplit_pkg::cmd_t                       cmd,
	output cmdsplit_pkg::stat_t                      stat,
	output logic                                     out_tvalid,
	input  wire                                      out_tready,
	output logic [cmdsplit_pkg::KIND_W-1:0]          out_kind,
	output logic [cmdsplit_pkg::CHAR_W-1:0]          out_char,
	output logic [cmdsplit_pkg::CNT_W-1:0]           arg_count,
	output logic [cmdsplit_pkg::CNT_W-1:0]           char_count,
	output logic                                     overrun,
	output logic                                     last
);
	import cmdsplit_pkg::*;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_GAP,
		PH_ARG
	} phase_t;

	phase_t            phase_q, phase_d;
	logic              quoted_q, quoted_d, quoted_eff;
	logic              pend_q, pend_d;
	logic [RUN_W-1:0]  run_q, run_d;
	logic [RUN_W-1:0]  slash_cnt_q;
	logic [CHAR_W-1:0] char_q, char_d;
	logic [CNT_W-1:0]  args_q, chars_q, chars_inc;
	logic              ovr_q;
	logic              args_inc, ovr_set, line_end, is_arg;
	logic              c_quote, c_bslash, c_blank, c_zero;
	plan_t             plan;

	always_comb begin
		c_quote  = in_char == CH_QUOTE;
		c_bslash = in_char == CH_BSLASH;
		c_blank  = (in_char == CH_SPACE) || (in_char == CH_TAB);
		c_zero   = in_char == CH_NUL;

		plan       = '0;
		phase_d    = phase_q;
		quoted_d   = quoted_q;
		quoted_eff = quoted_q;
		pend_d     = pend_q;
		run_d      = run_q;
		char_d     = in_char;
		args_inc   = 1'b0;
		ovr_set    = 1'b0;
		line_end   = 1'b0;
		is_arg     = 1'b0;

		case (phase_q)
			PH_FIRST: begin
				if (c_quote) begin
					quoted_d = ~quoted_q;
				end else if (c_zero) begin
					plan.term_en = 1'b1;
					plan.sum_en  = 1'b1;
					line_end     = 1'b1;
				end else if (c_blank && !quoted_q) begin
					plan.term_en = 1'b1;
					quoted_d     = 1'b0;
					phase_d      = PH_GAP;
				end else begin
					plan.char_en = 1'b1;
				end
			end
			PH_ARG: begin
				if (pend_q && c_quote) begin
					pend_d       = 1'b0;
					plan.char_en = 1'b1;
					char_d       = CH_QUOTE;
				end else begin
					if (pend_q) begin
						pend_d     = 1'b0;
						quoted_eff = 1'b0;
						quoted_d   = 1'b0;
					end
					is_arg = 1'b1;
				end
			end
			default: begin
				if (c_zero) begin
					plan.sum_en = 1'b1;
					line_end    = 1'b1;
				end else if (!c_blank) begin
					phase_d  = PH_ARG;
					args_inc = 1'b1;
					is_arg   = 1'b1;
				end
			end
		endcase

		if (is_arg) begin
			if (c_bslash) begin
				if (run_q < RUN_W'(MAX_RUN)) begin
					run_d = run_q + 1'b1;
				end else begin
					ovr_set = 1'b1;
				end
			end else begin
				run_d = '0;
				if (c_quote) begin
					plan.nsl = run_q >> 1;
					if (run_q[0]) begin
						plan.char_en = 1'b1;
						char_d       = CH_QUOTE;
					end else if (quoted_eff) begin
						pend_d = 1'b1;
					end else begin
						quoted_d = 1'b1;
					end
				end else begin
					plan.nsl = run_q;
					if (c_zero) begin
						plan.term_en = 1'b1;
						plan.sum_en  = 1'b1;
						line_end     = 1'b1;
					end else if (c_blank && !quoted_eff) begin
						plan.term_en = 1'b1;
						phase_d      = PH_GAP;
					end else begin
						plan.char_en = 1'b1;
					end
				end
			end
		end

		if (line_end) begin
			phase_d  = PH_FIRST;
			quoted_d = 1'b0;
			pend_d   = 1'b0;
			run_d    = '0;
		end

		chars_inc = (chars_q == CNT_MAX) ? chars_q : chars_q + 1'b1;

		stat.out_free  = !out_tvalid || out_tready;
		stat.slash_one = slash_cnt_q == RUN_W'(1);
		stat.plan      = plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			quoted_q    <= 1'b0;
			pend_q      <= 1'b0;
			run_q       <= '0;
			slash_cnt_q <= '0;
			args_q      <= CNT_W'(1);
			chars_q     <= '0;
			ovr_q       <= 1'b0;
			out_tvalid  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				phase_q  <= phase_d;
				quoted_q <= quoted_d;
				pend_q   <= pend_d;
				run_q    <= run_d;
			end

			if (cmd.accept) begin
				slash_cnt_q <= plan.nsl;
			end else if (cmd.load && cmd.sel == SEL_SLASH) begin
				slash_cnt_q <= slash_cnt_q - 1'b1;
			end

			if (cmd.load && cmd.sel == SEL_SUM) begin
				args_q  <= CNT_W'(1);
				chars_q <= '0;
				ovr_q   <= 1'b0;
			end else begin
				if (cmd.load) begin
					chars_q <= chars_inc;
				end
				if (cmd.accept && args_inc && args_q != CNT_MAX) begin
					args_q <= args_q + 1'b1;
				end
				if (cmd.accept && ovr_set) begin
					ovr_q <= 1'b1;
				end
			end

			if (cmd.load) begin
				out_tvalid <= 1'b1;
			end else if (out_tready) begin
				out_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= char_d;
		end
		if (cmd.load) begin
			arg_count <= args_q;
			overrun   <= ovr_q;
			last      <= cmd.last;
			case (cmd.sel)
				SEL_SLASH: begin
					out_kind   <= KIND_CHAR;
					out_char   <= CH_BSLASH;
					char_count <= chars_inc;
				end
				SEL_CHAR: begin
					out_kind   <= KIND_CHAR;
					out_char   <= char_q;
					char_count <= chars_inc;
				end
				SEL_TERM: begin
					out_kind   <= KIND_TERM;
					out_char   <= CH_NUL;
					char_count <= chars_inc;
				end
				default: begin
					out_kind   <= KIND_SUM;
					out_char   <= CH_NUL;
					char_count <= chars_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/command_line_argument_splitter.sv =====
// Top level of the command line argument splitter.
// A character's first result goes through the sequencer state register and then the result register to m_axis.
// One character is taken per cycle when it gives at most one result and m_axis is not stalled;
// otherwise input waits while the result sequencer drains the held backslash run one per cycle.
// Reset: asynchronous, clears the parse state; counters restart at one argument, no characters.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [15:0] in_char
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [15:0] out_char, [30:16] arg_count,
	                                   // [45:31] char_count, [46] overrun, [47] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
	output logic        m_axis_tlast   // last
);
	import cmdsplit_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [CHAR_W-1:0] out_char;
	logic [CNT_W-1:0]  arg_count, char_count;
	logic              overrun;

	cmdsplit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cmdsplit_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_char    (s_axis_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_char   (out_char),
		.arg_count  (arg_count),
		.char_count (char_count),
		.overrun    (overrun),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, overrun, char_count, arg_count, out_char};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the command line argument splitter.
`timescale 1ns / 1ps

module tb_top;
	import cmdsplit_pkg::*;

	localparam int DRAIN_MARK = -1;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_GAP,
		PH_ARG,
		PH_SPARE
	} split_phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
		logic [CNT_W-1:0]  args;
		logic [CNT_W-1:0]  chars;
		logic              ovr;
		logic              last;
	} split_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [47:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;
	wire         m_axis_tlast;

	command_line_argument_splitter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	int         line_q[$];
	split_res_t split_q[$];
	split_res_t step_res[$];
	int         total_items = 0;
	int         issued_items = 0;
	int         accepted_items = 0;
	int         errors = 0;
	int         cycles = 0;

	split_phase_t         ph;
	logic                 in_quotes;
	logic                 quote_hold;
	logic [RUN_W-1:0]     run_len;
	logic [CNT_W-1:0]     arg_total;
	logic [CNT_W-1:0]     char_total;
	logic                 run_overflow;

	task automatic line_restart();
		ph = PH_FIRST;
		in_quotes = 1'b0;
		quote_hold = 1'b0;
		run_len = '0;
		arg_total = CNT_W'(1);
		char_total = '0;
		run_overflow = 1'b0;
	endtask

	task automatic emit(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch);
		split_res_t r;
		if (step_res.size() >= 64)
			return;
		if (kind != KIND_SUM && char_total != CNT_MAX)
			char_total++;
		r.kind = kind;
		r.ch = ch;
		r.args = arg_total;
		r.chars = char_total;
		r.ovr = run_overflow;
		r.last = 1'b0;
		step_res.push_back(r);
	endtask

	task automatic spill_slashes(input int n);
		for (int i = 0; i < n; i++)
			emit(KIND_CHAR, CH_BSLASH);
	endtask

	task automatic close_line();
		emit(KIND_SUM, CH_NUL);
		line_restart();
	endtask

	task automatic count_slash();
		if (run_len < MAX_RUN)
			run_len++;
		else
			run_overflow = 1'b1;
	endtask

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	task automatic arg_step(input logic [CHAR_W-1:0] c);
		int n;
		n = int'(run_len);
		run_len = '0;
		if (c == CH_QUOTE) begin
			spill_slashes(n >> 1);
			if (n % 2 == 1)
				emit(KIND_CHAR, CH_QUOTE);
			else if (in_quotes)
				quote_hold = 1'b1;
			else
				in_quotes = 1'b1;
		end else begin
			spill_slashes(n);
			if (c == CH_NUL) begin
				emit(KIND_TERM, CH_NUL);
				close_line();
			end else if (!in_quotes && is_blank(c)) begin
				emit(KIND_TERM, CH_NUL);
				ph = PH_GAP;
			end else begin
				emit(KIND_CHAR, c);
			end
		end
	endtask

	task automatic split_char(input logic [CHAR_W-1:0] c);
		logic done;
		done = 1'b0;
		step_res.delete();
		case (ph)
			PH_FIRST: begin
				if (c == CH_QUOTE) begin
					in_quotes = ~in_quotes;
				end else if (c == CH_NUL) begin
					emit(KIND_TERM, CH_NUL);
					close_line();
				end else if (!in_quotes && is_blank(c)) begin
					emit(KIND_TERM, CH_NUL);
					in_quotes = 1'b0;
					ph = PH_GAP;
				end else begin
					emit(KIND_CHAR, c);
				end
			end
			PH_ARG: begin
				if (quote_hold) begin
					quote_hold = 1'b0;
					if (c == CH_QUOTE) begin
						emit(KIND_CHAR, CH_QUOTE);
						done = 1'b1;
					end else begin
						in_quotes = 1'b0;
					end
				end
				if (!done) begin
					if (c == CH_BSLASH)
						count_slash();
					else
						arg_step(c);
				end
			end
			default: begin
				if (c == CH_NUL) begin
					close_line();
				end else if (!is_blank(c)) begin
					ph = PH_ARG;
					if (arg_total != CNT_MAX)
						arg_total++;
					if (c == CH_BSLASH)
						count_slash();
					else
						arg_step(c);
				end
			end
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			split_q.push_back(step_res[i]);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	initial line_restart();

	// Check output transfers and predict from input transfers.
	always @(posedge clk) begin
		split_res_t head;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (split_q.size() == 0) begin
				$error("unexpected result: kind %0d char %0h", m_axis_tuser, m_axis_tdata[15:0]);
				errors++;
			end else begin
				head = split_q.pop_front();
				check_field("out_kind", head.kind, m_axis_tuser);
				check_field("out_char", head.ch, m_axis_tdata[15:0]);
				check_field("arg_count", head.args, m_axis_tdata[30:16]);
				check_field("char_count", head.chars, m_axis_tdata[45:31]);
				check_field("overrun", head.ovr, m_axis_tdata[46]);
				check_field("last", head.last, m_axis_tlast);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			split_char(s_axis_tdata);
			accepted_items++;
		end
	end

	int   burst_left = 0;
	int   gap_left = 0;
	logic hold_for_drain = 1'b0;

	always @(negedge clk) begin
		logic              nv;
		logic [CHAR_W-1:0] nd;
		int                item;
		nv = s_axis_tvalid;
		nd = s_axis_tdata;
		if (arst_n) begin
			if (s_axis_tvalid && accepted_items == issued_items)
				nv = 1'b0;
			if (!nv) begin
				if (hold_for_drain) begin
					if (split_q.size() == 0)
						hold_for_drain = 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (line_q.size() > 0) begin
					item = line_q.pop_front();
					if (item == DRAIN_MARK) begin
						hold_for_drain = 1'b1;
					end else begin
						nv = 1'b1;
						nd = item[15:0];
						issued_items++;
						if (burst_left == 0) begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end else begin
							burst_left--;
						end
					end
				end
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tdata <= nd;
	end

	int   rx_mode = 0;
	int   rx_left = 0;
	int   long_hold = 0;
	logic long_done = 1'b0;

	always @(negedge clk) begin
		logic r;
		if (!arst_n) begin
			r = 1'b0;
		end else if (long_hold > 0) begin
			r = 1'b0;
			long_hold--;
		end else if (!long_done && accepted_items >= 120) begin
			long_done = 1'b1;
			long_hold = 400;
			r = 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_mode)
				0: r = 1'b1;
				1: r = $urandom_range(0, 1);
				2: r = ($urandom_range(0, 3) == 0);
				default: r = ~m_axis_tready;
			endcase
		end
		m_axis_tready <= r;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic push_unit(input int c);
		line_q.push_back(c);
		total_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_unit(s[i]);
	endtask

	initial begin
		int  toks;
		int  sel;
		int  len;
		int  long_runs;
		logic paused;
		long_runs = 0;
		paused = 1'b0;

		push_unit(CH_NUL);
		push_text("\"p q\"\\\t");
		push_text("\\\\\"x\"\"y\" ");
		push_text("\\\"");
		push_unit(16'hFFFF);
		push_unit(16'h0001);
		push_unit(CH_NUL);

		while (total_items < 450) begin
			if (!paused && total_items >= 250) begin
				line_q.push_back(DRAIN_MARK);
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					push_unit($urandom_range(0, 65535));
			end else begin
				toks = $urandom_range(0, 7);
				for (int t = 0; t < toks; t++) begin
					sel = $urandom_range(0, 99);
					if (sel < 30) begin
						len = $urandom_range(1, 2);
						for (int i = 0; i < len; i++)
							push_unit($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
					end else if (sel < 45) begin
						push_unit(CH_QUOTE);
					end else if (sel < 60) begin
						if (long_runs < 3 && $urandom_range(0, 11) == 0) begin
							len = $urandom_range(60, 70);
							long_runs++;
						end else begin
							len = $urandom_range(1, 5);
						end
						for (int i = 0; i < len; i++)
							push_unit(CH_BSLASH);
					end else if (sel < 88) begin
						len = $urandom_range(1, 4);
						for (int i = 0; i < len; i++)
							push_unit($urandom_range(33, 126));
					end else begin
						push_unit($urandom_range(1, 65535));
					end
				end
			end
			push_unit(CH_NUL);
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (accepted_items != total_items)
			@(posedge clk);
		while (split_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
